// File: hdl/assert_macros.svh
// Assertion helpers used by the checker in rrs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is asserted.
`define RRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("check failed");

// Clocked check, active in every cycle.
`define RRS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("check failed");

`endif

// File: hdl/rrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrs_pkg;

    localparam int TAG_W = 16;
    localparam int DUR_W = 16;

    typedef enum logic {
        REQ_ARRIVAL = 1'b0,
        REQ_TICK    = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RAN  = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } t_status;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [DUR_W-1:0] rem;
        logic             run;
    } t_entry;

endpackage
`default_nettype wire

// File: hdl/rrs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rrs_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [rrs_pkg::TAG_W-1:0] task_tag;
    logic [rrs_pkg::DUR_W-1:0] task_duration;

    modport source (output valid, req_type, task_tag, task_duration, input ready);
    modport sink   (input valid, req_type, task_tag, task_duration, output ready);
endinterface
`default_nettype wire

// File: hdl/rrs_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rrs_res_if;
    logic                      valid;
    logic                      ready;
    rrs_pkg::t_status          status;
    logic [rrs_pkg::TAG_W-1:0] run_tag;
    logic                      first_run;
    logic                      finished;

    modport source (output valid, status, run_tag, first_run, finished, input ready);
    modport sink   (input valid, status, run_tag, first_run, finished, output ready);
endinterface
`default_nettype wire

// File: hdl/rrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rrs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first: a read of the entry being written returns the new data
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/rrs_free_enc.sv
`timescale 1ns / 1ps
`default_nettype none
module rrs_free_enc #(
    parameter int N = 16
) (
    input  wire logic [N-1:0]         i_used,
    output logic                      o_found,
    output logic      [$clog2(N)-1:0] o_idx
);

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_found = 1'b1;
                o_idx   = ($clog2(N))'(i);
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake         | Payload
// i_req   | in  | valid/ready       | req_type, task_tag, task_duration
// o_res   | out | valid/ready       | status, run_tag, first_run, finished
//
// One beat per cycle unless a full output stalls: a request is registered, processed
// against the slot tables, and its result (if any) lands in the output register.
// Slot tables sit in two synchronous-read memories addressed by the next current
// slot, so the current entry is always ready at the start of a cycle.
// Reset (i_rst_n low, synchronous) empties the ring and frees every slot.
// A full output register stalls only requests that produce a result.
module round_robin_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrs_req_if.sink    i_req,
    rrs_res_if.source  o_res
);
    import rrs_pkg::*;

    localparam int LW = $clog2(MAX_TASKS);

    logic             r_in_valid;
    logic             r_in_type;
    logic [TAG_W-1:0] r_in_tag;
    logic [DUR_W-1:0] r_in_dur;

    logic [MAX_TASKS-1:0] r_used, n_used;
    logic [LW-1:0]        r_cur, n_cur;
    logic [LW-1:0]        r_prev, n_prev;
    logic                 r_empty, n_empty;

    logic             r_out_valid;
    t_status          r_out_status, n_status;
    logic [TAG_W-1:0] r_out_tag, n_tag;
    logic             r_out_first, n_first;
    logic             r_out_fin, n_fin;

    logic          free_found;
    logic [LW-1:0] free_idx;
    logic          has_res;
    logic          advance;
    logic          in_ready;

    logic          d_we;
    logic [LW-1:0] d_waddr;
    t_entry        d_wdata;
    t_entry        d_rdata;
    logic          l_we;
    logic [LW-1:0] l_waddr;
    logic [LW-1:0] l_wdata;
    logic [LW-1:0] l_rdata;
    logic [LW-1:0] cur_link;

    rrs_free_enc #(.N(MAX_TASKS)) u_free_enc (
        .i_used  (r_used),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    rrs_ram #(.DEPTH(MAX_TASKS), .WIDTH($bits(t_entry))) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (n_cur),
        .o_rdata (d_rdata)
    );

    rrs_ram #(.DEPTH(MAX_TASKS), .WIDTH(LW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (n_cur),
        .o_rdata (l_rdata)
    );

    // the previous slot's link is implied: it always points at the current slot
    assign cur_link = (r_cur == r_prev) ? r_cur : l_rdata;

    always_comb begin
        has_res = 1'b0;
        if (r_in_type == REQ_TICK) begin
            has_res = 1'b1;
        end else if (!free_found || (r_in_dur == '0)) begin
            has_res = 1'b1;
        end
    end

    assign advance  = r_in_valid && (!has_res || !r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || advance;

    always_comb begin
        n_used   = r_used;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_empty  = r_empty;
        d_we     = 1'b0;
        d_waddr  = r_cur;
        d_wdata  = d_rdata;
        l_we     = 1'b0;
        l_waddr  = r_prev;
        l_wdata  = r_cur;
        n_status = ST_IDLE;
        n_tag    = '0;
        n_first  = 1'b0;
        n_fin    = 1'b0;
        if (advance) begin
            if (r_in_type == REQ_ARRIVAL) begin
                n_tag = r_in_tag;
                if (!free_found) begin
                    n_status = ST_FULL;
                end else if (r_in_dur == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    n_used[free_idx] = 1'b1;
                    d_we             = 1'b1;
                    d_waddr          = free_idx;
                    d_wdata.tag      = r_in_tag;
                    d_wdata.rem      = r_in_dur;
                    d_wdata.run      = 1'b0;
                    if (r_empty) begin
                        n_prev  = free_idx;
                        n_empty = 1'b0;
                    end else begin
                        l_we    = 1'b1;
                        l_waddr = free_idx;
                        l_wdata = r_cur;
                    end
                    n_cur = free_idx;
                end
            end else if (!r_empty) begin
                n_status = ST_RAN;
                n_tag    = d_rdata.tag;
                n_first  = !d_rdata.run;
                if (d_rdata.rem <= DUR_W'(1)) begin
                    n_fin         = 1'b1;
                    n_used[r_cur] = 1'b0;
                    if (cur_link == r_cur) begin
                        n_empty = 1'b1;
                    end else begin
                        n_cur = cur_link;
                    end
                end else begin
                    d_we        = 1'b1;
                    d_waddr     = r_cur;
                    d_wdata.rem = d_rdata.rem - DUR_W'(1);
                    d_wdata.run = 1'b1;
                    l_we        = 1'b1;
                    l_waddr     = r_prev;
                    l_wdata     = r_cur;
                    n_prev      = r_cur;
                    n_cur       = cur_link;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_type <= i_req.req_type;
            r_in_tag  <= i_req.task_tag;
            r_in_dur  <= i_req.task_duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_cur   <= '0;
            r_prev  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_used  <= n_used;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_res) begin
            r_out_status <= n_status;
            r_out_tag    <= n_tag;
            r_out_first  <= n_first;
            r_out_fin    <= n_fin;
        end
    end

    assign i_req.ready     = in_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.run_tag   = r_out_tag;
    assign o_res.first_run = r_out_first;
    assign o_res.finished  = r_out_fin;

endmodule
`default_nettype wire

// File: hdl/rrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rrs_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire rrs_pkg::t_status          i_status,
    input wire logic [rrs_pkg::TAG_W-1:0] i_run_tag,
    input wire logic                      i_first_run,
    input wire logic                      i_finished
);
    import rrs_pkg::*;

    `RRS_ASSERT(a_idle_clean, i_clk, i_rst_n, (i_out_valid && i_status == ST_IDLE) |-> (i_run_tag == '0 && !i_first_run && !i_finished))
    `RRS_ASSERT(a_reject_flags, i_clk, i_rst_n, (i_out_valid && (i_status == ST_FULL || i_status == ST_ZERO)) |-> (!i_first_run && !i_finished))
    `RRS_ASSERT(a_ready_when_out_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)
    `RRS_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status) && $stable(i_run_tag) && $stable(i_finished)))
    `RRS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind round_robin_task_scheduler_core rrs_checker u_rrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_run_tag   (o_res.run_tag),
    .i_first_run (o_res.first_run),
    .i_finished  (o_res.finished)
);
`default_nettype wire
